FILE: rtl/core/clt_pkg.sv
// shared types, constants and helpers of the command line tokenizer
// no dependencies; used by the core modules and the checker
package clt_pkg;

    localparam int LINE_LEN  = 1024;
    localparam int ARG_LIMIT = 64;

    localparam int CH_W    = 8;
    localparam int CNT_W   = 7;
    localparam int POS_W   = 10;
    localparam int KIND_W  = 2;
    localparam int ROLE_W  = 2;
    localparam int ERR_W   = 3;

    localparam logic [POS_W-1:0] POS_MAX        = POS_W'(LINE_LEN - 1);
    localparam logic [CNT_W-1:0] ARG_LIMIT_VAL  = CNT_W'(ARG_LIMIT);
    localparam logic [CNT_W-1:0] MAX_ARGS_RESET = 7'd16;

    // result queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // result kinds
    localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd3;

    // argument roles, also used for the pending redirect
    localparam logic [ROLE_W-1:0] ROLE_PLAIN = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_IN    = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_OUT   = 2'd2;

    // error codes
    localparam logic [ERR_W-1:0] ERR_TOO_MANY   = 3'd0;
    localparam logic [ERR_W-1:0] ERR_IN_REPEAT  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_OUT_REPEAT = 3'd2;
    localparam logic [ERR_W-1:0] ERR_IN_NAME    = 3'd3;
    localparam logic [ERR_W-1:0] ERR_OUT_NAME   = 3'd4;
    localparam logic [ERR_W-1:0] ERR_PIPE       = 3'd5;
    localparam logic [ERR_W-1:0] ERR_SEMICOLON  = 3'd6;
    localparam logic [ERR_W-1:0] ERR_UNTERM     = 3'd7;

    typedef struct packed {
        logic [CH_W-1:0] ch;
    } t_byte_in;

    typedef struct packed {
        logic [CNT_W-1:0] max_args;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0] rkind;
        logic [CH_W-1:0]   data;
        logic [ROLE_W-1:0] role;
        logic [CNT_W-1:0]  arg_index;
        logic [ERR_W-1:0]  error_code;
        logic [POS_W-1:0]  position;
        logic [CNT_W-1:0]  arg_total;
        logic              in_redirected;
        logic              out_redirected;
        logic              last;
    } t_result;

    // up to two results produced by one byte
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    function automatic t_result make_res(
        input logic [KIND_W-1:0] kind,
        input logic [CH_W-1:0]   data,
        input logic [ROLE_W-1:0] role,
        input logic [ERR_W-1:0]  err,
        input logic [CNT_W-1:0]  cnt,
        input logic [POS_W-1:0]  pos,
        input logic              ins,
        input logic              outs
    );
        t_result r;
        logic    done;
        done             = (kind == KIND_DONE);
        r.rkind          = kind;
        r.data           = data;
        r.role           = role;
        r.arg_index      = cnt;
        r.error_code     = err;
        r.position       = pos;
        r.arg_total      = done ? cnt : '0;
        r.in_redirected  = done & ins;
        r.out_redirected = done & outs;
        r.last           = 1'b0;
        return r;
    endfunction

endpackage

FILE: rtl/core/clt_stream_if.sv
// valid/ready channel carrying one payload of type T
// no dependencies
interface clt_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, input ready, output data);
    modport sink   (input valid, output ready, input data);
endinterface

FILE: rtl/core/clt_parser.sv
// per-byte tokenizer decision logic and command state registers
// depends on clt_pkg
module clt_parser
    import clt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [CH_W-1:0]  i_ch,
    input  logic [CNT_W-1:0] i_max_args,
    output t_push            o_push
);

    localparam logic [1:0] MODE_BETWEEN = 2'd0;
    localparam logic [1:0] MODE_WORD    = 2'd1;
    localparam logic [1:0] MODE_STRING  = 2'd2;
    localparam logic [1:0] MODE_DISCARD = 2'd3;

    localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CH_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CH_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CH_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CH_W-1:0] CH_LT     = 8'h3C;
    localparam logic [CH_W-1:0] CH_GT     = 8'h3E;
    localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CH_W-1:0] CH_PIPE   = 8'h7C;

    function automatic logic [CH_W-1:0] unescape(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] r;
        unique case (c)
            8'h61:   r = 8'h07;  // a
            8'h74:   r = 8'h09;  // t
            8'h66:   r = 8'h0C;  // f
            8'h6E:   r = 8'h0A;  // n
            8'h72:   r = 8'h0D;  // r
            default: r = c;
        endcase
        return r;
    endfunction

    logic [1:0]        r_mode, n_mode;
    logic              r_dq, n_dq;
    logic              r_esc, n_esc;
    logic [ROLE_W-1:0] r_pend, n_pend;
    logic [ROLE_W-1:0] r_role, n_role;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_ins, n_ins;
    logic              r_outs, n_outs;
    logic [POS_W-1:0]  r_pos, n_pos;

    logic              blank, brk, is_quote, is_redir;
    logic [CH_W-1:0]   quote;
    logic [CNT_W-1:0]  limit;
    logic              fin_req, beg_req, stop;
    logic              a_vld, b_vld;
    t_result           a_res, b_res;
    t_push             push;

    always_comb begin
        blank    = (i_ch == CH_SPACE) || (i_ch >= CH_TAB && i_ch <= CH_CR);
        is_quote = (i_ch == CH_DQUOTE) || (i_ch == CH_SQUOTE);
        is_redir = (i_ch == CH_LT) || (i_ch == CH_GT);
        brk      = blank || is_quote || is_redir || (i_ch == CH_HASH) ||
                   (i_ch == CH_PIPE) || (i_ch == CH_SEMI) || (i_ch == CH_NUL);
        quote    = r_dq ? CH_DQUOTE : CH_SQUOTE;
        limit    = (i_max_args < ARG_LIMIT_VAL) ? i_max_args : ARG_LIMIT_VAL;
    end

    always_comb begin
        n_mode = r_mode;
        n_dq   = r_dq;
        n_esc  = r_esc;
        n_pend = r_pend;
        n_role = r_role;
        n_cnt  = r_cnt;
        n_ins  = r_ins;
        n_outs = r_outs;
        n_pos  = r_pos;
        stop   = 1'b0;
        a_vld  = 1'b0;
        b_vld  = 1'b0;
        a_res  = '0;
        b_res  = '0;

        // end of the current token
        fin_req = (r_mode == MODE_WORD && brk) ||
                  (r_mode == MODE_STRING && !r_esc && i_ch == quote);
        if (fin_req) begin
            n_mode = MODE_BETWEEN;
            a_vld  = 1'b1;
            if (r_role == ROLE_PLAIN) begin
                if (r_cnt >= limit) begin
                    a_res = make_res(KIND_ERROR, '0, ROLE_PLAIN, ERR_TOO_MANY,
                                     r_cnt, r_pos, r_ins, r_outs);
                    stop  = 1'b1;
                end else begin
                    a_res = make_res(KIND_END, '0, ROLE_PLAIN, ERR_TOO_MANY,
                                     r_cnt, r_pos, r_ins, r_outs);
                    n_cnt = r_cnt + 7'd1;
                end
            end else begin
                if (r_role == ROLE_IN) begin
                    n_ins = 1'b1;
                end else begin
                    n_outs = 1'b1;
                end
                a_res  = make_res(KIND_END, '0, r_role, ERR_TOO_MANY,
                                  r_cnt, r_pos, r_ins, r_outs);
                n_role = ROLE_PLAIN;
            end
        end

        // the break byte that ended a word also starts the next token
        beg_req = (r_mode == MODE_BETWEEN) || (r_mode == MODE_WORD && brk && !stop);
        if (beg_req && !blank) begin
            if (i_ch == CH_NUL || i_ch == CH_HASH ||
                (r_pend != ROLE_PLAIN && (is_redir || i_ch == CH_PIPE || i_ch == CH_SEMI)))
            begin
                b_vld = 1'b1;
                stop  = 1'b1;
                if (r_pend != ROLE_PLAIN) begin
                    b_res = make_res(KIND_ERROR, '0, ROLE_PLAIN,
                                     (r_pend == ROLE_IN) ? ERR_IN_NAME : ERR_OUT_NAME,
                                     n_cnt, r_pos, n_ins, n_outs);
                end else begin
                    b_res = make_res(KIND_DONE, '0, ROLE_PLAIN, ERR_TOO_MANY,
                                     n_cnt, r_pos, n_ins, n_outs);
                end
            end else if (is_redir) begin
                if (i_ch == CH_LT && n_ins) begin
                    b_vld = 1'b1;
                    stop  = 1'b1;
                    b_res = make_res(KIND_ERROR, '0, ROLE_PLAIN, ERR_IN_REPEAT,
                                     n_cnt, r_pos, n_ins, n_outs);
                end else if (i_ch == CH_GT && n_outs) begin
                    b_vld = 1'b1;
                    stop  = 1'b1;
                    b_res = make_res(KIND_ERROR, '0, ROLE_PLAIN, ERR_OUT_REPEAT,
                                     n_cnt, r_pos, n_ins, n_outs);
                end else begin
                    n_pend = (i_ch == CH_LT) ? ROLE_IN : ROLE_OUT;
                end
            end else if (i_ch == CH_PIPE || i_ch == CH_SEMI) begin
                b_vld = 1'b1;
                stop  = 1'b1;
                b_res = make_res(KIND_ERROR, '0, ROLE_PLAIN,
                                 (i_ch == CH_PIPE) ? ERR_PIPE : ERR_SEMICOLON,
                                 n_cnt, r_pos, n_ins, n_outs);
            end else begin
                n_role = r_pend;
                n_pend = ROLE_PLAIN;
                if (is_quote) begin
                    n_mode = MODE_STRING;
                    n_dq   = (i_ch == CH_DQUOTE);
                    n_esc  = 1'b0;
                end else begin
                    n_mode = MODE_WORD;
                    b_vld  = 1'b1;
                    b_res  = make_res(KIND_BYTE, i_ch, r_pend, ERR_TOO_MANY,
                                      n_cnt, r_pos, n_ins, n_outs);
                end
            end
        end

        if (r_mode == MODE_WORD && !brk) begin
            b_vld = 1'b1;
            b_res = make_res(KIND_BYTE, i_ch, r_role, ERR_TOO_MANY,
                             r_cnt, r_pos, r_ins, r_outs);
        end

        if (r_mode == MODE_STRING && !fin_req) begin
            if (i_ch == CH_NUL) begin
                b_vld = 1'b1;
                stop  = 1'b1;
                b_res = make_res(KIND_ERROR, '0, ROLE_PLAIN,
                                 (r_role == ROLE_PLAIN) ? ERR_UNTERM :
                                 (r_role == ROLE_IN) ? ERR_IN_NAME : ERR_OUT_NAME,
                                 r_cnt, r_pos, r_ins, r_outs);
            end else if (r_esc) begin
                n_esc = 1'b0;
                b_vld = 1'b1;
                b_res = make_res(KIND_BYTE, unescape(i_ch), r_role, ERR_TOO_MANY,
                                 r_cnt, r_pos, r_ins, r_outs);
            end else if (i_ch == CH_BSLASH) begin
                n_esc = 1'b1;
            end else begin
                b_vld = 1'b1;
                b_res = make_res(KIND_BYTE, i_ch, r_role, ERR_TOO_MANY,
                                 r_cnt, r_pos, r_ins, r_outs);
            end
        end

        // a zero byte clears the whole command, discarded or not
        if (i_ch == CH_NUL) begin
            n_mode = MODE_BETWEEN;
            n_dq   = 1'b0;
            n_esc  = 1'b0;
            n_pend = ROLE_PLAIN;
            n_role = ROLE_PLAIN;
            n_cnt  = '0;
            n_ins  = 1'b0;
            n_outs = 1'b0;
            n_pos  = '0;
        end else begin
            if (stop) begin
                n_mode = MODE_DISCARD;
            end
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + 10'd1;
            end
        end
    end

    always_comb begin
        push = '0;
        if (i_step) begin
            push.count = {1'b0, a_vld} + {1'b0, b_vld};
            if (a_vld) begin
                push.first  = a_res;
                push.second = b_res;
                push.first.last  = !b_vld;
                push.second.last = 1'b1;
            end else begin
                push.first      = b_res;
                push.first.last = 1'b1;
            end
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BETWEEN;
            r_dq   <= 1'b0;
            r_esc  <= 1'b0;
            r_pend <= ROLE_PLAIN;
            r_role <= ROLE_PLAIN;
            r_cnt  <= '0;
            r_ins  <= 1'b0;
            r_outs <= 1'b0;
            r_pos  <= '0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_dq   <= n_dq;
            r_esc  <= n_esc;
            r_pend <= n_pend;
            r_role <= n_role;
            r_cnt  <= n_cnt;
            r_ins  <= n_ins;
            r_outs <= n_outs;
            r_pos  <= n_pos;
        end
    end

endmodule

FILE: rtl/core/clt_outq.sv
// result queue: takes up to two results a cycle, hands out one
// depends on clt_pkg and clt_stream_if
module clt_outq
    import clt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push,
    output logic       o_room,
    clt_stream_if.source o_res
);

    t_result               r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   r_wr, n_wr;
    logic [OQ_PTR_W-1:0]   r_rd, n_rd;
    logic [OQ_CNT_W-1:0]   r_cnt, n_cnt;
    logic                  pop;

    assign pop         = o_res.valid && o_res.ready;
    assign o_res.valid = (r_cnt != '0);
    assign o_res.data  = r_mem[r_rd];
    // room for the worst case of two results from one byte
    assign o_room      = (r_cnt <= OQ_CNT_W'(OQ_DEPTH - 2));

    always_comb begin
        n_wr  = r_wr + OQ_PTR_W'(i_push.count);
        n_rd  = r_rd + OQ_PTR_W'(pop);
        n_cnt = r_cnt + OQ_CNT_W'(i_push.count) - OQ_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + OQ_PTR_W'(1)] <= i_push.second;
        end
    end

endmodule

FILE: rtl/core/command_line_tokenizer_top.sv
// command line tokenizer top level: input register, config register,
// tokenizer core and result queue; depends on clt_pkg, clt_stream_if,
// clt_parser and clt_outq
//
// Usage:
//   i_byte   carries one command-line byte (ch) per request; a zero byte
//            ends the command and clears its state
//   i_cfg    writes max_args; always ready, write only while idle
//   o_result carries argument bytes, argument ends and one final done or
//            error result per command; last marks the final result of a byte
// Path: an accepted byte waits in the input register until the queue has
//   room, then its results are written into the queue that drives o_result.
// Throughput: one byte per cycle; the input register steps whenever the
//   four-entry result queue has room for two results, and a byte that gives
//   two results needs two handshakes on o_result.
// Reset: synchronous, active low; clears command state, empties the queue
//   and sets max_args to 16.
// Stall: when o_result is not taken the queue fills, the input register
//   holds its byte and i_byte.ready drops; nothing is lost.
module command_line_tokenizer_top
    import clt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    clt_stream_if.sink   i_byte,
    clt_stream_if.sink   i_cfg,
    clt_stream_if.source o_result
);

    logic             r_in_vld;
    logic [CH_W-1:0]  r_ch;
    logic [CNT_W-1:0] r_max_args;
    logic             room;
    logic             step;
    t_push            push;

    assign step         = r_in_vld && room;
    assign i_byte.ready = !r_in_vld || step;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_max_args <= MAX_ARGS_RESET;
        end else begin
            if (i_byte.ready) begin
                r_in_vld <= i_byte.valid;
            end
            if (i_cfg.valid) begin
                r_max_args <= i_cfg.data.max_args;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_ch <= i_byte.data.ch;
        end
    end

    clt_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_ch       (r_ch),
        .i_max_args (r_max_args),
        .o_push     (push)
    );

    clt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_res   (o_result)
    );

endmodule

FILE: rtl/core/clt_checker.sv
// port-level checks on the tokenizer result channel, bound to the top level
// depends on clt_pkg and command_line_tokenizer_top
module clt_checker
    import clt_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_res_valid,
    input logic    i_res_ready,
    input t_result i_res
);

    // a stalled request keeps its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res)))
        else $error("result changed while stalled");

    // done and error always close the byte's results
    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && (i_res.rkind == KIND_DONE || i_res.rkind == KIND_ERROR))
        |-> i_res.last)
        else $error("done or error not marked last");

    // summary fields only travel with done
    a_summary_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res.rkind != KIND_DONE)
        |-> (i_res.arg_total == '0 && !i_res.in_redirected && !i_res.out_redirected))
        else $error("summary fields set outside done");

    // only argument bytes carry data; ends and done carry no error code
    a_payload_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res.rkind != KIND_BYTE)
        |-> (i_res.data == '0 &&
             (i_res.rkind == KIND_ERROR || i_res.error_code == '0)))
        else $error("payload field set for wrong result kind");

endmodule

bind command_line_tokenizer_top clt_checker u_clt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_result.valid),
    .i_res_ready (o_result.ready),
    .i_res       (o_result.data)
);
